[src/npps_pkg.sv]
// ----------------------------------------------------------------------------
// npps_pkg: shared types and constants of the priority scheduler
// Transfer item formats, descriptor store layout, controller/datapath links.
// ----------------------------------------------------------------------------
package npps_pkg;

  // sizing
  localparam int MaxProcs  = 16;
  localparam int TimeBits  = 16;
  localparam int IdxW      = (MaxProcs > 1) ? $clog2(MaxProcs) : 1;
  localparam int CntW      = $clog2(MaxProcs + 1);
  localparam int ArrW      = 16;
  localparam int PriW      = 8;
  localparam int TimeW     = 21;
  localparam int SumW      = 25;
  localparam int PidW      = 7;

  localparam logic [TimeW-1:0] TimeMax  = {TimeW{1'b1}};
  localparam logic [SumW-1:0]  SumMax   = {SumW{1'b1}};
  localparam logic [ArrW-1:0]  TimeMask =
      (TimeBits >= ArrW) ? {ArrW{1'b1}} : ArrW'((32'd1 << TimeBits) - 32'd1);

  // input transfer
  typedef struct packed {
    logic [ArrW-1:0] arrival_time;
    logic [ArrW-1:0] burst_time;
    logic [PriW-1:0] priority_req;
    logic            last_process;
  } in_item_t;

  // output transfer
  typedef struct packed {
    logic [PidW-1:0]  process_id;
    logic [TimeW-1:0] start_time;
    logic [TimeW-1:0] finish_time;
    logic [TimeW-1:0] turnaround;
    logic [TimeW-1:0] waiting;
    logic [SumW-1:0]  total_waiting;
    logic [SumW-1:0]  total_turnaround;
    logic             last_result;
  } out_item_t;

  // one stored descriptor
  typedef struct packed {
    logic [ArrW-1:0] arrival;
    logic [ArrW-1:0] burst;
    logic [PriW-1:0] prio;
  } desc_t;

  localparam int DescW = $bits(desc_t);

  // controller -> datapath
  typedef struct packed {
    logic load;       // input transfer taken
    logic scan_init;  // restart selection scan
    logic rd_en;      // issue next store read
    logic adv_time;   // jump time to next arrival
    logic emit;       // build result from best entry
    logic clear;      // end of set, back to reset values
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic rd_last;    // read issued at last loaded entry
    logic found;      // some arrived entry is pending
    logic all_done;   // every loaded entry dispatched
  } ctrl_sts_t;

endpackage

[src/npps_ram.sv]
// ----------------------------------------------------------------------------
// npps_ram: generic single-port-write RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module npps_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/npps_ctrl.sv]
// ----------------------------------------------------------------------------
// npps_ctrl: scheduler sequencer
// Load, scan, drain, decide and output phases; drives the datapath commands.
// ----------------------------------------------------------------------------
module npps_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_last_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  npps_pkg::ctrl_sts_t  sts_i,
  output npps_pkg::ctrl_cmd_t  cmd_o
);
  import npps_pkg::*;

  typedef enum logic [4:0] {
    S_LOAD   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_DRAIN  = 5'b00100,
    S_DECIDE = 5'b01000,
    S_OUT    = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_LOAD: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i) begin
            cmd_o.scan_init = 1'b1;
            state_d         = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd_o.rd_en = 1'b1;
        if (sts_i.rd_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts_i.found) begin
          cmd_o.emit = 1'b1;
          state_d    = S_OUT;
        end else begin
          cmd_o.adv_time  = 1'b1;
          cmd_o.scan_init = 1'b1;
          state_d         = S_SCAN;
        end
      end
      S_OUT: begin
        if (out_ready_i) begin
          if (sts_i.all_done) begin
            cmd_o.clear = 1'b1;
            state_d     = S_LOAD;
          end else begin
            cmd_o.scan_init = 1'b1;
            state_d         = S_SCAN;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o  = (state_q == S_LOAD);
  assign out_valid_o = (state_q == S_OUT);

endmodule

[src/npps_dp.sv]
// ----------------------------------------------------------------------------
// npps_dp: scheduler datapath
// Descriptor store, done flags, selection scan, time and sum arithmetic.
// ----------------------------------------------------------------------------
module npps_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  npps_pkg::ctrl_cmd_t  cmd_i,
  input  npps_pkg::in_item_t   in_data_i,
  output npps_pkg::ctrl_sts_t  sts_o,
  output npps_pkg::out_item_t  out_data_o
);
  import npps_pkg::*;

  logic [CntW-1:0]     loaded_q, loaded_d;
  logic [CntW-1:0]     done_cnt_q, done_cnt_d;
  logic [MaxProcs-1:0] done_q, done_d;
  logic [TimeW-1:0]    cur_time_q, cur_time_d;
  logic [SumW-1:0]     wait_sum_q, wait_sum_d;
  logic [SumW-1:0]     tat_sum_q, tat_sum_d;
  logic [IdxW-1:0]     rd_idx_q, rd_idx_d;
  logic [IdxW-1:0]     cmp_idx_q;
  logic                cmp_vld_q, cmp_vld_d;
  logic                found_q, found_d;
  logic [TimeW-1:0]    next_arr_q, next_arr_d;
  logic [IdxW-1:0]     best_idx_q, best_idx_d;
  desc_t               best_q, best_d;
  out_item_t           out_q;

  logic                full;
  desc_t               wr_desc;
  desc_t               rd_desc;
  logic [TimeW-1:0]    rd_arr;
  logic [TimeW:0]      fin_sum;
  logic [TimeW-1:0]    finish;
  logic [TimeW-1:0]    best_arr;
  logic [TimeW-1:0]    tat;
  logic [TimeW-1:0]    wt;
  logic [SumW:0]       wsum_raw;
  logic [SumW:0]       tsum_raw;
  logic [SumW-1:0]     wsum_sat;
  logic [SumW-1:0]     tsum_sat;

  assign full = (loaded_q == CntW'(MaxProcs));

  // masked descriptor on load
  assign wr_desc.arrival = in_data_i.arrival_time & TimeMask;
  assign wr_desc.burst   = in_data_i.burst_time & TimeMask;
  assign wr_desc.prio    = in_data_i.priority_req;

  npps_ram #(
    .Width(DescW),
    .Depth(MaxProcs)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.load && !full),
    .waddr_i(loaded_q[IdxW-1:0]),
    .wdata_i(wr_desc),
    .re_i   (cmd_i.rd_en),
    .raddr_i(rd_idx_q),
    .rdata_o(rd_desc)
  );

  assign rd_arr = TimeW'(rd_desc.arrival);

  // result arithmetic for the chosen entry
  assign best_arr = TimeW'(best_q.arrival);
  assign fin_sum  = {1'b0, cur_time_q} + (TimeW + 1)'(best_q.burst);
  assign finish   = fin_sum[TimeW] ? TimeMax : fin_sum[TimeW-1:0];
  assign tat      = finish - best_arr;
  assign wt       = cur_time_q - best_arr;
  assign wsum_raw = {1'b0, wait_sum_q} + (SumW + 1)'(wt);
  assign tsum_raw = {1'b0, tat_sum_q} + (SumW + 1)'(tat);
  assign wsum_sat = wsum_raw[SumW] ? SumMax : wsum_raw[SumW-1:0];
  assign tsum_sat = tsum_raw[SumW] ? SumMax : tsum_raw[SumW-1:0];

  // next-state logic
  always_comb begin
    loaded_d   = loaded_q;
    done_cnt_d = done_cnt_q;
    done_d     = done_q;
    cur_time_d = cur_time_q;
    wait_sum_d = wait_sum_q;
    tat_sum_d  = tat_sum_q;
    rd_idx_d   = rd_idx_q;
    cmp_vld_d  = cmd_i.rd_en;
    found_d    = found_q;
    next_arr_d = next_arr_q;
    best_idx_d = best_idx_q;
    best_d     = best_q;

    // load a descriptor; a full store drops it
    if (cmd_i.load && !full) begin
      loaded_d               = loaded_q + CntW'(1);
      done_d[loaded_q[IdxW-1:0]] = 1'b0;
    end

    // read address walk
    if (cmd_i.rd_en) begin
      rd_idx_d = rd_idx_q + IdxW'(1);
    end

    // compare one entry per cycle
    if (cmp_vld_q && !done_q[cmp_idx_q]) begin
      if (rd_arr <= cur_time_q) begin
        if (!found_q || (rd_desc.prio < best_q.prio)) begin
          found_d    = 1'b1;
          best_idx_d = cmp_idx_q;
          best_d     = rd_desc;
        end
      end else if (rd_arr < next_arr_q) begin
        next_arr_d = rd_arr;
      end
    end

    // no arrival yet: jump to the earliest pending one
    if (cmd_i.adv_time) begin
      cur_time_d = next_arr_q;
    end

    // dispatch the chosen entry
    if (cmd_i.emit) begin
      cur_time_d         = finish;
      done_d[best_idx_q] = 1'b1;
      done_cnt_d         = done_cnt_q + CntW'(1);
      wait_sum_d         = wsum_sat;
      tat_sum_d          = tsum_sat;
    end

    if (cmd_i.scan_init) begin
      rd_idx_d   = '0;
      cmp_vld_d  = 1'b0;
      found_d    = 1'b0;
      next_arr_d = TimeMax;
    end

    if (cmd_i.clear) begin
      loaded_d   = '0;
      done_cnt_d = '0;
      done_d     = '0;
      cur_time_d = '0;
      wait_sum_d = '0;
      tat_sum_d  = '0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q   <= '0;
      done_cnt_q <= '0;
      done_q     <= '0;
      cur_time_q <= '0;
      wait_sum_q <= '0;
      tat_sum_q  <= '0;
      rd_idx_q   <= '0;
      cmp_vld_q  <= 1'b0;
      found_q    <= 1'b0;
    end else begin
      loaded_q   <= loaded_d;
      done_cnt_q <= done_cnt_d;
      done_q     <= done_d;
      cur_time_q <= cur_time_d;
      wait_sum_q <= wait_sum_d;
      tat_sum_q  <= tat_sum_d;
      rd_idx_q   <= rd_idx_d;
      cmp_vld_q  <= cmp_vld_d;
      found_q    <= found_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmp_idx_q  <= rd_idx_q;
    next_arr_q <= next_arr_d;
    best_idx_q <= best_idx_d;
    best_q     <= best_d;
    if (cmd_i.emit) begin
      out_q.process_id       <= PidW'(best_idx_q) + PidW'(1);
      out_q.start_time       <= cur_time_q;
      out_q.finish_time      <= finish;
      out_q.turnaround       <= tat;
      out_q.waiting          <= wt;
      out_q.total_waiting    <= wsum_sat;
      out_q.total_turnaround <= tsum_sat;
      out_q.last_result      <= ((done_cnt_q + CntW'(1)) == loaded_q);
    end
  end

  assign sts_o.rd_last  = (rd_idx_q == IdxW'(loaded_q - CntW'(1)));
  assign sts_o.found    = found_q;
  assign sts_o.all_done = (done_cnt_q == loaded_q);
  assign out_data_o     = out_q;

endmodule

[src/nonpreemptive_priority_scheduler.sv]
// ----------------------------------------------------------------------------
// nonpreemptive_priority_scheduler: non-preemptive priority scheduler
// Loads process descriptors, then dispatches them lowest priority number
// first among arrived processes, one result per dispatch.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+---------------------------
//  in       | input     | in_valid_i / in_ready_o | in_data_i  (in_item_t)
//  out      | output    | out_valid_o/out_ready_i | out_data_o (out_item_t)
//
//  Loading accepts descriptors while ready is high; ready is low from the
//  final one until the last result of the set is taken.
//  Each dispatch scans the N stored entries through the store's single read
//  port, and a jump over idle time adds another scan before it; output
//  stalls add to the time that a set takes.
//  Reset clears the done flags, counters and sums; the store is not cleared.
//  A stalled result holds the scheduler in its output state.
// ----------------------------------------------------------------------------
module nonpreemptive_priority_scheduler (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  npps_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output npps_pkg::out_item_t  out_data_o
);
  import npps_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  npps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_data_i.last_process),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  npps_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .in_data_i (in_data_i),
    .sts_o     (sts),
    .out_data_o(out_data_o)
  );

`ifndef NO_ASSERTIONS
  // loading and output never overlap
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a result is pending");

  // the final result of a set returns the block to loading
  a_last_reloads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && out_data_o.last_result) |=> in_ready_o)
    else $error("no return to loading after final result");

  // a process never finishes before it starts
  a_finish_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.finish_time >= out_data_o.start_time))
    else $error("finish time below start time");

  // waiting never exceeds turnaround
  a_wait_le_tat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.waiting <= out_data_o.turnaround))
    else $error("waiting time above turnaround");
`endif

endmodule
